>>> hdl/dmac_pkg.sv
package dmac_pkg;

    // channel count and fixed field widths
    localparam int NUM_CH  = 4;
    localparam int ADDR_W  = 28;
    localparam int COUNT_W = 21;
    localparam int DATA_W  = 32;

    // address and count limits
    localparam logic [ADDR_W-1:0]  ADDR_MASK_NARROW     = 28'h7fffffe;
    localparam logic [ADDR_W-1:0]  ADDR_MASK_WIDE       = 28'hffffffe;
    localparam logic [COUNT_W-1:0] COUNT_MASK_FULL      = 21'h1fffff;
    localparam logic [COUNT_W-1:0] COUNT_MASK_ARM7      = 21'h003fff;
    localparam logic [COUNT_W-1:0] COUNT_MASK_ARM7_LAST = 21'h00ffff;
    localparam logic [DATA_W-1:0]  CTRL_FIELDS_MASK     = 32'hffe00000;

    // channel that keeps the wide limits in arm7 mode
    localparam logic [1:0] WIDE_CH = 2'd3;

    // address step modes (0 and 3 increment)
    localparam logic [1:0] STEP_DEC    = 2'd1;
    localparam logic [1:0] STEP_FIXED  = 2'd2;
    localparam logic [1:0] STEP_RELOAD = 2'd3;

    // trigger codes that start a channel at once
    localparam logic [2:0] TRIG_NOW     = 3'd0;
    localparam logic [2:0] TRIG_NOW_ALT = 3'd7;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_TRIGGER = 2'd2,
        OP_STEP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        SEL_CONTROL = 2'd0,
        SEL_SOURCE  = 2'd1,
        SEL_DEST    = 2'd2,
        SEL_FILL    = 2'd3
    } reg_sel_t;

    // controller to datapath
    typedef struct packed {
        logic exec;
        op_t  op;
    } cmd_t;

    // datapath to one channel
    typedef struct packed {
        logic wr_ctrl;
        logic wr_src;
        logic wr_dst;
        logic wr_fill;
        logic trig;
        logic step;
    } lane_cmd_t;

    // one channel back to the datapath
    typedef struct packed {
        logic              running;
        logic              hit;
        logic              done_irq;
        logic              is_word;
        logic [ADDR_W-1:0] cur_src;
        logic [ADDR_W-1:0] cur_dst;
        logic [DATA_W-1:0] ctrl_word;
        logic [ADDR_W-1:0] init_src;
        logic [ADDR_W-1:0] init_dst;
        logic [DATA_W-1:0] fill;
    } lane_stat_t;

    // signed address step for one unit
    function automatic logic [ADDR_W-1:0] step_delta(logic [1:0] mode, logic word);
        logic [ADDR_W-1:0] d;
        case (mode)
            STEP_DEC:   d = word ? 28'hffffffc : 28'hffffffe;
            STEP_FIXED: d = '0;
            default:    d = word ? 28'd4 : 28'd2;
        endcase
        return d;
    endfunction

endpackage

>>> hdl/dmac_ctrl.sv
module dmac_ctrl
    import dmac_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_command,
    output logic       m_valid,
    input  logic       m_ready,
    output cmd_t       cmd
);

    typedef enum logic {
        ST_EMPTY,
        ST_FULL
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    // output slot free, or being emptied this cycle
    assign s_ready = (state_reg == ST_EMPTY) || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = (state_reg == ST_FULL);

    // command to the datapath
    assign cmd.exec = accept;
    assign cmd.op   = op_t'(s_command);

    // result slot tracking
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EMPTY: begin
                if (accept) state_next = ST_FULL;
            end
            ST_FULL: begin
                if (!accept && m_ready) state_next = ST_EMPTY;
            end
            default: state_next = ST_EMPTY;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_EMPTY;
        end else begin
            state_reg <= state_next;
        end
    end

    // every accepted item yields a result next cycle
    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted transfer did not produce a result");

    // a held result blocks new input
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while result stalled");

    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

>>> hdl/dmac_chan.sv
module dmac_chan
    import dmac_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        lane_id,
    input  logic              arm7_mode,
    input  lane_cmd_t         cmd,
    input  logic [DATA_W-1:0] wdata,
    input  logic [DATA_W-1:0] wmask,
    input  logic [2:0]        tval,
    output lane_stat_t        stat
);

    logic [ADDR_W-1:0]  init_src_reg, init_src_next;
    logic [ADDR_W-1:0]  init_dst_reg, init_dst_next;
    logic [COUNT_W-1:0] init_count_reg, init_count_next;
    logic [DATA_W-1:0]  fill_reg, fill_next;
    logic [ADDR_W-1:0]  cur_src_reg, cur_src_next;
    logic [ADDR_W-1:0]  cur_dst_reg, cur_dst_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [1:0]         dmode_reg, dmode_next;
    logic [1:0]         smode_reg, smode_next;
    logic               repeat_reg, repeat_next;
    logic               word_reg, word_next;
    logic [2:0]         tsrc_reg, tsrc_next;
    logic               irq_en_reg, irq_en_next;
    logic               enable_reg, enable_next;
    logic               running_reg, running_next;

    logic [COUNT_W-1:0] cm;
    logic [ADDR_W-1:0]  sm, dm, src_m, dst_m;
    logic [2:0]         tsrc_new;
    logic [COUNT_W-1:0] rem_dec;
    logic               hit, done_irq;

    // per-channel limits
    always_comb begin
        if (!arm7_mode) cm = COUNT_MASK_FULL;
        else if (lane_id == WIDE_CH) cm = COUNT_MASK_ARM7_LAST;
        else cm = COUNT_MASK_ARM7;
    end
    assign sm = (arm7_mode && lane_id == 2'd0) ? ADDR_MASK_NARROW : ADDR_MASK_WIDE;
    assign dm = (arm7_mode && lane_id != WIDE_CH) ? ADDR_MASK_NARROW : ADDR_MASK_WIDE;

    assign src_m    = wmask[ADDR_W-1:0] & sm;
    assign dst_m    = wmask[ADDR_W-1:0] & dm;
    assign tsrc_new = arm7_mode ? {1'b0, wdata[29:28]} : wdata[29:27];
    assign rem_dec  = rem_reg - 1'b1;

    // register writes, trigger and one transfer step
    always_comb begin
        init_src_next   = init_src_reg;
        init_dst_next   = init_dst_reg;
        init_count_next = init_count_reg;
        fill_next       = fill_reg;
        cur_src_next    = cur_src_reg;
        cur_dst_next    = cur_dst_reg;
        rem_next        = rem_reg;
        dmode_next      = dmode_reg;
        smode_next      = smode_reg;
        repeat_next     = repeat_reg;
        word_next       = word_reg;
        tsrc_next       = tsrc_reg;
        irq_en_next     = irq_en_reg;
        enable_next     = enable_reg;
        running_next    = running_reg;
        hit             = 1'b0;
        done_irq        = 1'b0;

        if (cmd.wr_ctrl) begin
            if (|(wmask[COUNT_W-1:0] & cm)) begin
                init_count_next = (init_count_reg & ~cm) | (wdata[COUNT_W-1:0] & cm);
            end
            if (|(wmask & CTRL_FIELDS_MASK)) begin
                dmode_next  = wdata[22:21];
                smode_next  = wdata[24:23];
                repeat_next = wdata[25];
                word_next   = wdata[26];
                tsrc_next   = tsrc_new;
                irq_en_next = wdata[30];
                enable_next = wdata[31];
                if (wdata[31]) begin
                    // rising enable latches the start values
                    if (!enable_reg) begin
                        cur_src_next = init_src_reg;
                        cur_dst_next = init_dst_reg;
                        rem_next     = init_count_next;
                    end
                    if (tsrc_new == TRIG_NOW || tsrc_new == TRIG_NOW_ALT) begin
                        running_next = 1'b1;
                    end
                end else begin
                    running_next = 1'b0;
                end
            end
        end

        if (cmd.wr_src) begin
            init_src_next = (init_src_reg & ~src_m) | (wdata[ADDR_W-1:0] & src_m);
        end
        if (cmd.wr_dst) begin
            init_dst_next = (init_dst_reg & ~dst_m) | (wdata[ADDR_W-1:0] & dst_m);
        end
        if (cmd.wr_fill && !arm7_mode) begin
            fill_next = (fill_reg & ~wmask) | (wdata & wmask);
        end

        if (cmd.trig && enable_reg && tsrc_reg == tval) begin
            running_next = 1'b1;
            hit          = 1'b1;
        end

        if (cmd.step) begin
            cur_src_next = (cur_src_reg + step_delta(smode_reg, word_reg)) & sm;
            cur_dst_next = (cur_dst_reg + step_delta(dmode_reg, word_reg)) & dm;
            rem_next     = rem_dec;
            // end of run
            if ((rem_dec & cm) == '0) begin
                if (dmode_reg == STEP_RELOAD) cur_dst_next = init_dst_reg;
                if (repeat_reg) rem_next = init_count_reg;
                else enable_next = 1'b0;
                running_next = 1'b0;
                done_irq     = irq_en_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_src_reg   <= '0;
            init_dst_reg   <= '0;
            init_count_reg <= '0;
            fill_reg       <= '0;
            cur_src_reg    <= '0;
            cur_dst_reg    <= '0;
            rem_reg        <= '0;
            dmode_reg      <= '0;
            smode_reg      <= '0;
            repeat_reg     <= 1'b0;
            word_reg       <= 1'b0;
            tsrc_reg       <= '0;
            irq_en_reg     <= 1'b0;
            enable_reg     <= 1'b0;
            running_reg    <= 1'b0;
        end else begin
            init_src_reg   <= init_src_next;
            init_dst_reg   <= init_dst_next;
            init_count_reg <= init_count_next;
            fill_reg       <= fill_next;
            cur_src_reg    <= cur_src_next;
            cur_dst_reg    <= cur_dst_next;
            rem_reg        <= rem_next;
            dmode_reg      <= dmode_next;
            smode_reg      <= smode_next;
            repeat_reg     <= repeat_next;
            word_reg       <= word_next;
            tsrc_reg       <= tsrc_next;
            irq_en_reg     <= irq_en_next;
            enable_reg     <= enable_next;
            running_reg    <= running_next;
        end
    end

    // status back to the datapath
    assign stat.running   = running_reg;
    assign stat.hit       = hit;
    assign stat.done_irq  = done_irq;
    assign stat.is_word   = word_reg;
    assign stat.cur_src   = cur_src_reg;
    assign stat.cur_dst   = cur_dst_reg;
    assign stat.ctrl_word = {enable_reg, irq_en_reg, tsrc_reg, word_reg, repeat_reg,
                             smode_reg, dmode_reg, init_count_reg};
    assign stat.init_src  = init_src_reg;
    assign stat.init_dst  = init_dst_reg;
    assign stat.fill      = fill_reg;

endmodule

>>> hdl/dmac_datapath.sv
module dmac_datapath
    import dmac_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic [1:0]        channel,
    input  logic [1:0]        register_select,
    input  logic [DATA_W-1:0] write_data,
    input  logic [DATA_W-1:0] write_mask,
    input  logic [NUM_CH-1:0] trigger_channels,
    input  logic [2:0]        trigger_value,
    output logic [DATA_W-1:0] read_data,
    output logic              trigger_hit,
    output logic              copy_valid,
    output logic [1:0]        copy_channel,
    output logic [ADDR_W-1:0] copy_source,
    output logic [ADDR_W-1:0] copy_dest,
    output logic              copy_is_word,
    output logic [NUM_CH-1:0] irq_raise,
    output logic [NUM_CH-1:0] active_mask
);

    logic              arm7_reg;
    lane_cmd_t         lane_cmd [NUM_CH];
    lane_stat_t        lane_stat [NUM_CH];
    logic              found;
    logic [1:0]        pick;
    lane_stat_t        rd_lane, cp_lane;
    logic [NUM_CH-1:0] hits, irqs;

    logic [DATA_W-1:0] read_data_reg, read_data_next;
    logic              hit_reg, hit_next;
    logic              cv_reg, cv_next;
    logic [1:0]        cc_reg, cc_next;
    logic [ADDR_W-1:0] cs_reg, cs_next;
    logic [ADDR_W-1:0] cd_reg, cd_next;
    logic              cw_reg, cw_next;
    logic [NUM_CH-1:0] irq_reg, irq_next;

    // mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arm7_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            arm7_reg <= cfg_wr_data;
        end
    end

    // lowest running channel takes the step
    always_comb begin
        found = 1'b0;
        pick  = '0;
        for (int i = 0; i < NUM_CH; i++) begin
            if (lane_stat[i].running && !found) begin
                found = 1'b1;
                pick  = 2'(i);
            end
        end
    end

    // per-channel command decode
    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            lane_cmd[i].wr_ctrl = cmd.exec && cmd.op == OP_WRITE && channel == 2'(i)
                                  && register_select == SEL_CONTROL;
            lane_cmd[i].wr_src  = cmd.exec && cmd.op == OP_WRITE && channel == 2'(i)
                                  && register_select == SEL_SOURCE;
            lane_cmd[i].wr_dst  = cmd.exec && cmd.op == OP_WRITE && channel == 2'(i)
                                  && register_select == SEL_DEST;
            lane_cmd[i].wr_fill = cmd.exec && cmd.op == OP_WRITE && channel == 2'(i)
                                  && register_select == SEL_FILL;
            lane_cmd[i].trig    = cmd.exec && cmd.op == OP_TRIGGER && trigger_channels[i];
            lane_cmd[i].step    = cmd.exec && cmd.op == OP_STEP && found && pick == 2'(i);
            hits[i]             = lane_stat[i].hit;
            irqs[i]             = lane_stat[i].done_irq;
            active_mask[i]      = lane_stat[i].running;
        end
    end

    for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
        dmac_chan u_chan (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .lane_id   (2'(g)),
            .arm7_mode (arm7_reg),
            .cmd       (lane_cmd[g]),
            .wdata     (write_data),
            .wmask     (write_mask),
            .tval      (trigger_value),
            .stat      (lane_stat[g])
        );
    end

    assign rd_lane = lane_stat[channel];
    assign cp_lane = lane_stat[pick];

    // result for the current transfer
    always_comb begin
        read_data_next = '0;
        hit_next       = 1'b0;
        cv_next        = 1'b0;
        cc_next        = '0;
        cs_next        = '0;
        cd_next        = '0;
        cw_next        = 1'b0;
        irq_next       = '0;
        case (cmd.op)
            OP_READ: begin
                unique case (reg_sel_t'(register_select))
                    SEL_CONTROL: read_data_next = rd_lane.ctrl_word;
                    SEL_SOURCE:  read_data_next = DATA_W'(rd_lane.init_src);
                    SEL_DEST:    read_data_next = DATA_W'(rd_lane.init_dst);
                    SEL_FILL:    read_data_next = rd_lane.fill;
                    default:     read_data_next = '0;
                endcase
            end
            OP_TRIGGER: begin
                hit_next = |hits;
            end
            OP_STEP: begin
                if (found) begin
                    cv_next = 1'b1;
                    cc_next = pick;
                    cs_next = cp_lane.cur_src;
                    cd_next = cp_lane.cur_dst;
                    cw_next = cp_lane.is_word;
                end
                irq_next = irqs;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            read_data_reg <= read_data_next;
            hit_reg       <= hit_next;
            cv_reg        <= cv_next;
            cc_reg        <= cc_next;
            cs_reg        <= cs_next;
            cd_reg        <= cd_next;
            cw_reg        <= cw_next;
            irq_reg       <= irq_next;
        end
    end

    assign read_data    = read_data_reg;
    assign trigger_hit  = hit_reg;
    assign copy_valid   = cv_reg;
    assign copy_channel = cc_reg;
    assign copy_source  = cs_reg;
    assign copy_dest    = cd_reg;
    assign copy_is_word = cw_reg;
    assign irq_raise    = irq_reg;

    // a step never drives more than one channel
    a_one_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({lane_cmd[3].step, lane_cmd[2].step, lane_cmd[1].step, lane_cmd[0].step}))
        else $error("step issued to several channels");

    // an interrupt only comes from the stepped channel
    a_irq_from_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (|irqs) |-> (cmd.exec && cmd.op == OP_STEP && found))
        else $error("interrupt without a step");

    // a finished copy came from a channel that was running
    a_copy_running: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && cmd.op == OP_STEP && found) |-> lane_stat[pick].running)
        else $error("copy from an idle channel");

endmodule

>>> hdl/four_channel_dma_controller_unit.sv
// Four-channel DMA controller.
// Input channel (s_valid/s_ready): one command per transfer - register write,
// register read, trigger event or transfer step. Result channel (m_valid/m_ready):
// exactly one result per command, in order, carrying read data, trigger hit,
// the copy request (channel, source, destination, size), interrupt bits and the
// set of running channels after the command.
// A command accepted at an edge has its result valid right after that edge.
// Throughput is one command per cycle while the receiver takes results; each
// command updates the per-channel registers in the same cycle that loads the
// output register. When the receiver stalls, the result is held and s_ready
// stays low until the held result is taken, so nothing is lost or repeated.
// cfg_wr_en/cfg_wr_data write the arm7 mode bit, which selects narrow address
// and count limits, halved trigger codes and no fill writes; write it only
// while the block is idle.
// Synchronous active-low reset clears all channel registers, the mode bit and
// the output valid; the block accepts commands in the first cycle after reset.
// Memory access is left to the receiver of the copy requests.
module four_channel_dma_controller_unit
    import dmac_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_command,
    input  logic [1:0]        s_channel,
    input  logic [1:0]        s_register_select,
    input  logic [DATA_W-1:0] s_write_data,
    input  logic [DATA_W-1:0] s_write_mask,
    input  logic [NUM_CH-1:0] s_trigger_channels,
    input  logic [2:0]        s_trigger_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_read_data,
    output logic              m_trigger_hit,
    output logic              m_copy_valid,
    output logic [1:0]        m_copy_channel,
    output logic [ADDR_W-1:0] m_copy_source,
    output logic [ADDR_W-1:0] m_copy_dest,
    output logic              m_copy_is_word,
    output logic [NUM_CH-1:0] m_irq_raise,
    output logic [NUM_CH-1:0] m_active_mask
);

    cmd_t cmd;

    // handshake and command sequencing
    dmac_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd)
    );

    // channel registers and result register
    dmac_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .channel          (s_channel),
        .register_select  (s_register_select),
        .write_data       (s_write_data),
        .write_mask       (s_write_mask),
        .trigger_channels (s_trigger_channels),
        .trigger_value    (s_trigger_value),
        .read_data        (m_read_data),
        .trigger_hit      (m_trigger_hit),
        .copy_valid       (m_copy_valid),
        .copy_channel     (m_copy_channel),
        .copy_source      (m_copy_source),
        .copy_dest        (m_copy_dest),
        .copy_is_word     (m_copy_is_word),
        .irq_raise        (m_irq_raise),
        .active_mask      (m_active_mask)
    );

endmodule

>>> sim/tb_four_channel_dma_controller_unit.sv
`timescale 1ns / 100ps

module tb_four_channel_dma_controller_unit;
    import dmac_pkg::*;

    localparam int          CLK_PERIOD     = 10;
    localparam int unsigned CYCLE_LIMIT    = 1000000;
    localparam int unsigned SQUEEZE_CYCLES = 200;
    localparam int unsigned PHASE_ITEMS    = 280;

    // one result transfer as the block should present it
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              trigger_hit;
        logic              copy_valid;
        logic [1:0]        copy_channel;
        logic [ADDR_W-1:0] copy_source;
        logic [ADDR_W-1:0] copy_dest;
        logic              copy_is_word;
        logic [NUM_CH-1:0] irq_raise;
        logic [NUM_CH-1:0] active_mask;
    } dma_result_t;

    // one row of the directed command list
    typedef struct {
        op_t               cmd;
        logic [1:0]        ch;
        reg_sel_t          sel;
        logic [DATA_W-1:0] data;
        logic [DATA_W-1:0] mask;
        logic [NUM_CH-1:0] tch;
        logic [2:0]        tval;
        bit                pinned;
        dma_result_t       want;
    } script_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic              cfg_wr_data = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_command = '0;
    logic [1:0]        s_channel = '0;
    logic [1:0]        s_register_select = '0;
    logic [DATA_W-1:0] s_write_data = '0;
    logic [DATA_W-1:0] s_write_mask = '0;
    logic [NUM_CH-1:0] s_trigger_channels = '0;
    logic [2:0]        s_trigger_value = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [DATA_W-1:0] m_read_data;
    logic              m_trigger_hit;
    logic              m_copy_valid;
    logic [1:0]        m_copy_channel;
    logic [ADDR_W-1:0] m_copy_source;
    logic [ADDR_W-1:0] m_copy_dest;
    logic              m_copy_is_word;
    logic [NUM_CH-1:0] m_irq_raise;
    logic [NUM_CH-1:0] m_active_mask;

    // typed expectation travelling alongside a directed command
    logic              pin_on = 1'b0;
    dma_result_t       pin_res = '0;

    // shadow copy of the channel registers
    logic              arm7;
    logic [ADDR_W-1:0] init_src [NUM_CH];
    logic [ADDR_W-1:0] init_dst [NUM_CH];
    logic [ADDR_W-1:0] cur_src  [NUM_CH];
    logic [ADDR_W-1:0] cur_dst  [NUM_CH];
    logic [COUNT_W-1:0] init_cnt [NUM_CH];
    logic [COUNT_W-1:0] left_cnt [NUM_CH];
    logic [DATA_W-1:0] fill_w   [NUM_CH];
    logic [1:0]        dst_mode [NUM_CH];
    logic [1:0]        src_mode [NUM_CH];
    logic [2:0]        trig_code [NUM_CH];
    logic              rpt [NUM_CH];
    logic              word_unit [NUM_CH];
    logic              irq_en [NUM_CH];
    logic              ch_en [NUM_CH];
    logic              ch_run [NUM_CH];

    dma_result_t       pending_results [$];
    script_row_t       script [$];

    bit                idle_on = 1'b1;
    bit                squeeze_req = 1'b0;
    bit                squeeze_started = 1'b0;
    int unsigned       squeeze_left = 0;
    int unsigned       stall_left = 0;
    int unsigned       items_sent = 0;
    int unsigned       results_seen = 0;
    int unsigned       copies_seen = 0;
    int unsigned       hits_seen = 0;
    int unsigned       irqs_seen = 0;
    int unsigned       blocked_cycles = 0;
    int unsigned       cycle_count = 0;
    int unsigned       mismatches = 0;

    four_channel_dma_controller_unit uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_channel          (s_channel),
        .s_register_select  (s_register_select),
        .s_write_data       (s_write_data),
        .s_write_mask       (s_write_mask),
        .s_trigger_channels (s_trigger_channels),
        .s_trigger_value    (s_trigger_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_read_data        (m_read_data),
        .m_trigger_hit      (m_trigger_hit),
        .m_copy_valid       (m_copy_valid),
        .m_copy_channel     (m_copy_channel),
        .m_copy_source      (m_copy_source),
        .m_copy_dest        (m_copy_dest),
        .m_copy_is_word     (m_copy_is_word),
        .m_irq_raise        (m_irq_raise),
        .m_active_mask      (m_active_mask)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // per-channel limits of the current mode
    function automatic logic [COUNT_W-1:0] count_limit(int ch);
        if (!arm7) return COUNT_MASK_FULL;
        return (ch == WIDE_CH) ? COUNT_MASK_ARM7_LAST : COUNT_MASK_ARM7;
    endfunction

    function automatic logic [ADDR_W-1:0] src_limit(int ch);
        return (arm7 && ch == 0) ? ADDR_MASK_NARROW : ADDR_MASK_WIDE;
    endfunction

    function automatic logic [ADDR_W-1:0] dst_limit(int ch);
        return (arm7 && ch != WIDE_CH) ? ADDR_MASK_NARROW : ADDR_MASK_WIDE;
    endfunction

    // address advance for one unit, two's complement at address width
    function automatic logic [ADDR_W-1:0] addr_advance(logic [1:0] mode, logic word);
        logic [ADDR_W-1:0] unit;
        unit = word ? 28'd4 : 28'd2;
        if (mode == STEP_DEC) return 28'd0 - unit;
        if (mode == STEP_FIXED) return '0;
        return unit;
    endfunction

    function automatic dma_result_t outcome(logic [31:0] rd, logic hit, logic cv,
            logic [1:0] cc, logic [27:0] cs, logic [27:0] cd, logic cw,
            logic [3:0] irq, logic [3:0] act);
        dma_result_t r;
        r.read_data = rd;
        r.trigger_hit = hit;
        r.copy_valid = cv;
        r.copy_channel = cc;
        r.copy_source = cs;
        r.copy_dest = cd;
        r.copy_is_word = cw;
        r.irq_raise = irq;
        r.active_mask = act;
        return r;
    endfunction

    task automatic clear_shadow();
        arm7 = 1'b0;
        for (int i = 0; i < NUM_CH; i++) begin
            init_src[i] = '0; init_dst[i] = '0; cur_src[i] = '0; cur_dst[i] = '0;
            init_cnt[i] = '0; left_cnt[i] = '0; fill_w[i] = '0;
            dst_mode[i] = '0; src_mode[i] = '0; trig_code[i] = '0;
            rpt[i] = 1'b0; word_unit[i] = 1'b0; irq_en[i] = 1'b0;
            ch_en[i] = 1'b0; ch_run[i] = 1'b0;
        end
    endtask

    // applies one command to the shadow registers and returns its result
    function automatic dma_result_t apply_command(op_t cmd, logic [1:0] ch, reg_sel_t sel,
            logic [31:0] data, logic [31:0] mask, logic [3:0] tch, logic [2:0] tval);
        dma_result_t       r;
        logic [ADDR_W-1:0] m;
        logic [COUNT_W-1:0] cm;
        logic              was_en;
        int                lead;
        int                i;
        r = '0;
        case (cmd)
            OP_WRITE: begin
                case (sel)
                    SEL_CONTROL: begin
                        cm = count_limit(ch);
                        if (|(mask[COUNT_W-1:0] & cm))
                            init_cnt[ch] = (init_cnt[ch] & ~cm) | (data[COUNT_W-1:0] & cm);
                        if (|(mask & CTRL_FIELDS_MASK)) begin
                            was_en = ch_en[ch];
                            dst_mode[ch] = data[22:21];
                            src_mode[ch] = data[24:23];
                            rpt[ch] = data[25];
                            word_unit[ch] = data[26];
                            trig_code[ch] = arm7 ? {1'b0, data[29:28]} : data[29:27];
                            irq_en[ch] = data[30];
                            ch_en[ch] = data[31];
                            if (ch_en[ch]) begin
                                // a fresh enable latches the start values
                                if (!was_en) begin
                                    cur_src[ch] = init_src[ch];
                                    cur_dst[ch] = init_dst[ch];
                                    left_cnt[ch] = init_cnt[ch];
                                end
                                if (trig_code[ch] == TRIG_NOW || trig_code[ch] == TRIG_NOW_ALT)
                                    ch_run[ch] = 1'b1;
                            end else begin
                                ch_run[ch] = 1'b0;
                            end
                        end
                    end
                    SEL_SOURCE: begin
                        m = mask[ADDR_W-1:0] & src_limit(ch);
                        init_src[ch] = (init_src[ch] & ~m) | (data[ADDR_W-1:0] & m);
                    end
                    SEL_DEST: begin
                        m = mask[ADDR_W-1:0] & dst_limit(ch);
                        init_dst[ch] = (init_dst[ch] & ~m) | (data[ADDR_W-1:0] & m);
                    end
                    default: begin
                        if (!arm7) fill_w[ch] = (fill_w[ch] & ~mask) | (data & mask);
                    end
                endcase
            end
            OP_READ: begin
                case (sel)
                    SEL_CONTROL: r.read_data = {ch_en[ch], irq_en[ch], trig_code[ch],
                        word_unit[ch], rpt[ch], src_mode[ch], dst_mode[ch], init_cnt[ch]};
                    SEL_SOURCE:  r.read_data = {4'h0, init_src[ch]};
                    SEL_DEST:    r.read_data = {4'h0, init_dst[ch]};
                    default:     r.read_data = fill_w[ch];
                endcase
            end
            OP_TRIGGER: begin
                for (i = 0; i < NUM_CH; i++) begin
                    if (tch[i] && ch_en[i] && trig_code[i] == tval) begin
                        ch_run[i] = 1'b1;
                        r.trigger_hit = 1'b1;
                    end
                end
            end
            default: begin
                // lowest running channel moves one unit
                lead = -1;
                for (i = NUM_CH - 1; i >= 0; i--)
                    if (ch_run[i]) lead = i;
                if (lead >= 0) begin
                    r.copy_valid = 1'b1;
                    r.copy_channel = lead[1:0];
                    r.copy_source = cur_src[lead];
                    r.copy_dest = cur_dst[lead];
                    r.copy_is_word = word_unit[lead];
                    cur_src[lead] = (cur_src[lead]
                        + addr_advance(src_mode[lead], word_unit[lead])) & src_limit(lead);
                    cur_dst[lead] = (cur_dst[lead]
                        + addr_advance(dst_mode[lead], word_unit[lead])) & dst_limit(lead);
                    left_cnt[lead] = left_cnt[lead] - 1'b1;
                    // end of block: reload, repeat or disable
                    if ((left_cnt[lead] & count_limit(lead)) == '0) begin
                        if (dst_mode[lead] == STEP_RELOAD) cur_dst[lead] = init_dst[lead];
                        if (rpt[lead]) left_cnt[lead] = init_cnt[lead];
                        else ch_en[lead] = 1'b0;
                        ch_run[lead] = 1'b0;
                        if (irq_en[lead]) r.irq_raise[lead] = 1'b1;
                    end
                end
            end
        endcase
        for (i = 0; i < NUM_CH; i++)
            r.active_mask[i] = ch_run[i];
        return r;
    endfunction

    // idle length: mostly none, sometimes short, rarely long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!idle_on) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // offers one command and waits for its transfer
    task automatic send(op_t cmd, logic [1:0] ch, reg_sel_t sel, logic [31:0] data,
            logic [31:0] mask, logic [3:0] tch, logic [2:0] tval, bit pin,
            dma_result_t want);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_channel <= ch;
        s_register_select <= sel;
        s_write_data <= data;
        s_write_mask <= mask;
        s_trigger_channels <= tch;
        s_trigger_value <= tval;
        pin_on <= pin;
        pin_res <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // drains all results, then writes the mode bit while idle
    task automatic set_mode(logic value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        arm7 = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // a well-formed channel setup: stop, addresses, control, trigger, steps
    task automatic program_channel();
        logic [1:0]         ch;
        logic [2:0]         trig;
        logic [2:0]         code;
        logic [COUNT_W-1:0] cnt;
        logic [31:0]        ctrl;
        logic [31:0]        dmask;
        int unsigned        n;
        ch = 2'($urandom_range(0, 3));
        trig = 3'($urandom_range(0, 7));
        cnt = ($urandom_range(0, 39) == 0) ? COUNT_W'($urandom)
                                           : COUNT_W'($urandom_range(1, 6));
        dmask = ($urandom_range(0, 3) == 0) ? $urandom : 32'hffffffff;
        send(OP_WRITE, ch, SEL_CONTROL, $urandom & ~32'h80000000, CTRL_FIELDS_MASK,
             4'($urandom), 3'($urandom), 1'b0, '0);
        send(OP_WRITE, ch, SEL_SOURCE, $urandom, 32'hffffffff,
             4'($urandom), 3'($urandom), 1'b0, '0);
        send(OP_WRITE, ch, SEL_DEST, $urandom, dmask,
             4'($urandom), 3'($urandom), 1'b0, '0);
        ctrl = {1'b1, 1'($urandom), trig, 1'($urandom), 1'($urandom),
                2'($urandom), 2'($urandom), cnt};
        send(OP_WRITE, ch, SEL_CONTROL, ctrl, 32'hffffffff,
             4'($urandom), 3'($urandom), 1'b0, '0);
        code = arm7 ? (trig >> 1) : trig;
        if (code != TRIG_NOW && code != TRIG_NOW_ALT)
            send(OP_TRIGGER, 2'($urandom), reg_sel_t'($urandom_range(0, 3)), $urandom,
                 $urandom, 4'($urandom) | (4'b0001 << ch), code, 1'b0, '0);
        if ($urandom_range(0, 3) == 0)
            send(OP_READ, ch, SEL_CONTROL, $urandom, $urandom,
                 4'($urandom), 3'($urandom), 1'b0, '0);
        n = $urandom_range(1, 8);
        repeat (n)
            send(OP_STEP, 2'($urandom), reg_sel_t'($urandom_range(0, 3)), $urandom,
                 $urandom, 4'($urandom), 3'($urandom), 1'b0, '0);
    endtask

    // one unconstrained command with mostly short counts
    task automatic noise_item();
        logic [31:0] data;
        logic [31:0] mask;
        data = $urandom;
        if ($urandom_range(0, 3) != 0) data[COUNT_W-1:0] = COUNT_W'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
            0:       mask = 32'hffffffff;
            1:       mask = $urandom;
            2:       mask = CTRL_FIELDS_MASK;
            default: mask = 32'h001fffff;
        endcase
        send(op_t'($urandom_range(0, 3)), 2'($urandom), reg_sel_t'($urandom_range(0, 3)),
             data, mask, 4'($urandom), 3'($urandom), 1'b0, '0);
    endtask

    task automatic random_phase(int unsigned quota);
        int unsigned stop;
        stop = items_sent + quota;
        while (items_sent < stop) begin
            if ($urandom_range(0, 19) == 0) idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 6) program_channel();
            else noise_item();
        end
    endtask

    // result side: random stalls plus one long hold-off on request
    always @(posedge aclk) begin
        if (squeeze_req && !squeeze_started) begin
            squeeze_started = 1'b1;
            squeeze_left = SQUEEZE_CYCLES;
        end
        if (squeeze_left != 0) begin
            squeeze_left--;
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // scoreboard: check result transfers, predict accepted commands
    always @(posedge aclk) begin
        dma_result_t got;
        dma_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = outcome(m_read_data, m_trigger_hit, m_copy_valid, m_copy_channel,
                              m_copy_source, m_copy_dest, m_copy_is_word, m_irq_raise,
                              m_active_mask);
                if (pending_results.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    results_seen++;
                    if (want.copy_valid) copies_seen++;
                    if (want.trigger_hit) hits_seen++;
                    if (want.irq_raise != '0) irqs_seen++;
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("trigger_hit", want.trigger_hit, got.trigger_hit);
                    check_field("copy_valid", want.copy_valid, got.copy_valid);
                    check_field("copy_channel", want.copy_channel, got.copy_channel);
                    check_field("copy_source", want.copy_source, got.copy_source);
                    check_field("copy_dest", want.copy_dest, got.copy_dest);
                    check_field("copy_is_word", want.copy_is_word, got.copy_is_word);
                    check_field("irq_raise", want.irq_raise, got.irq_raise);
                    check_field("active_mask", want.active_mask, got.active_mask);
                end
            end
            if (s_valid && s_ready) begin
                want = apply_command(op_t'(s_command), s_channel,
                                     reg_sel_t'(s_register_select), s_write_data,
                                     s_write_mask, s_trigger_channels, s_trigger_value);
                if (pin_on) want = pin_res;
                pending_results.push_back(want);
            end
            if (s_valid && !s_ready) blocked_cycles++;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        script_row_t row;
        clear_shadow();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        set_mode(1'b0);

        // directed list, mode 0: reset values, masks, one short run,
        // trigger matching and retrigger, mask-only writes, trigger code 7
        script.push_back('{OP_READ, 2'd0, SEL_CONTROL, 32'h0, 32'h0, 4'h0, 3'd0, 1'b1,
                           outcome(0, 0, 0, 0, 0, 0, 0, 4'h0, 4'h0)});
        script.push_back('{OP_WRITE, 2'd0, SEL_SOURCE, 32'hffffffff, 32'hffffffff, 4'h0,
                           3'd0, 1'b1, outcome(0, 0, 0, 0, 0, 0, 0, 4'h0, 4'h0)});
        script.push_back('{OP_READ, 2'd0, SEL_SOURCE, 32'h0, 32'h0, 4'h0, 3'd0, 1'b1,
                           outcome(32'h0ffffffe, 0, 0, 0, 0, 0, 0, 4'h0, 4'h0)});
        script.push_back('{OP_WRITE, 2'd0, SEL_DEST, 32'h00001000, 32'hffffffff, 4'h0,
                           3'd0, 1'b1, outcome(0, 0, 0, 0, 0, 0, 0, 4'h0, 4'h0)});
        script.push_back('{OP_WRITE, 2'd1, SEL_FILL, 32'hdeadbeef, 32'h0000ffff, 4'h0,
                           3'd0, 1'b1, outcome(0, 0, 0, 0, 0, 0, 0, 4'h0, 4'h0)});
        script.push_back('{OP_READ, 2'd1, SEL_FILL, 32'h0, 32'h0, 4'h0, 3'd0, 1'b1,
                           outcome(32'h0000beef, 0, 0, 0, 0, 0, 0, 4'h0, 4'h0)});
        script.push_back('{OP_WRITE, 2'd0, SEL_CONTROL, 32'hc4200002, 32'hffffffff, 4'h0,
                           3'd0, 1'b1, outcome(0, 0, 0, 0, 0, 0, 0, 4'h0, 4'h1)});
        script.push_back('{OP_STEP, 2'd0, SEL_CONTROL, 32'h0, 32'h0, 4'h0, 3'd0, 1'b1,
                           outcome(0, 0, 1, 0, 28'hffffffe, 28'h0001000, 1, 4'h0, 4'h1)});
        script.push_back('{OP_STEP, 2'd0, SEL_CONTROL, 32'h0, 32'h0, 4'h0, 3'd0, 1'b1,
                           outcome(0, 0, 1, 0, 28'h0000002, 28'h0000ffc, 1, 4'h1, 4'h0)});
        script.push_back('{OP_STEP, 2'd3, SEL_FILL, 32'hffffffff, 32'hffffffff, 4'hf,
                           3'd7, 1'b1, outcome(0, 0, 0, 0, 0, 0, 0, 4'h0, 4'h0)});
        script.push_back('{OP_READ, 2'd0, SEL_CONTROL, 32'h0, 32'h0, 4'h0, 3'd0, 1'b1,
                           outcome(32'h44200002, 0, 0, 0, 0, 0, 0, 4'h0, 4'h0)});
        script.push_back('{OP_WRITE, 2'd2, SEL_DEST, 32'h0ffffffe, 32'hffffffff, 4'h0,
                           3'd0, 1'b0, '0});
        // zero count, repeat, fixed source, reloading destination, trigger 3
        script.push_back('{OP_WRITE, 2'd2, SEL_CONTROL, 32'h9b600000, 32'hffffffff, 4'h0,
                           3'd0, 1'b1, outcome(0, 0, 0, 0, 0, 0, 0, 4'h0, 4'h0)});
        script.push_back('{OP_TRIGGER, 2'd0, SEL_CONTROL, 32'h0, 32'h0, 4'hf, 3'd5, 1'b1,
                           outcome(0, 0, 0, 0, 0, 0, 0, 4'h0, 4'h0)});
        script.push_back('{OP_TRIGGER, 2'd0, SEL_CONTROL, 32'h0, 32'h0, 4'h4, 3'd3, 1'b1,
                           outcome(0, 1, 0, 0, 0, 0, 0, 4'h0, 4'h4)});
        script.push_back('{OP_TRIGGER, 2'd0, SEL_CONTROL, 32'h0, 32'h0, 4'hf, 3'd3, 1'b1,
                           outcome(0, 1, 0, 0, 0, 0, 0, 4'h0, 4'h4)});
        script.push_back('{OP_STEP, 2'd0, SEL_CONTROL, 32'h0, 32'h0, 4'h0, 3'd0, 1'b0, '0});
        script.push_back('{OP_STEP, 2'd0, SEL_CONTROL, 32'h0, 32'h0, 4'h0, 3'd0, 1'b0, '0});
        script.push_back('{OP_WRITE, 2'd1, SEL_CONTROL, 32'h80000001, 32'hffffffff, 4'h0,
                           3'd0, 1'b0, '0});
        script.push_back('{OP_STEP, 2'd0, SEL_CONTROL, 32'h0, 32'h0, 4'h0, 3'd0, 1'b0, '0});
        script.push_back('{OP_WRITE, 2'd3, SEL_CONTROL, 32'hffffffff, 32'h0, 4'h0, 3'd0,
                           1'b1, outcome(0, 0, 0, 0, 0, 0, 0, 4'h0, 4'h4)});
        script.push_back('{OP_WRITE, 2'd2, SEL_CONTROL, 32'h0, 32'h0000ffff, 4'h0, 3'd0,
                           1'b0, '0});
        script.push_back('{OP_WRITE, 2'd2, SEL_CONTROL, 32'h0, 32'h80000000, 4'h0, 3'd0,
                           1'b1, outcome(0, 0, 0, 0, 0, 0, 0, 4'h0, 4'h0)});
        script.push_back('{OP_WRITE, 2'd3, SEL_CONTROL, 32'hb8000001, 32'hffffffff, 4'h0,
                           3'd0, 1'b1, outcome(0, 0, 0, 0, 0, 0, 0, 4'h0, 4'h8)});
        script.push_back('{OP_STEP, 2'd0, SEL_CONTROL, 32'h0, 32'h0, 4'h0, 3'd0, 1'b0, '0});

        foreach (script[k]) begin
            row = script[k];
            send(row.cmd, row.ch, row.sel, row.data, row.mask, row.tch, row.tval,
                 row.pinned, row.want);
        end

        // random phases alternating the mode; long result hold-off in the first
        for (int p = 0; p < 4; p++) begin
            set_mode(p % 2 == 0);
            if (p == 0) begin
                random_phase(100);
                squeeze_req = 1'b1;
                random_phase(PHASE_ITEMS - 100);
            end else begin
                random_phase(PHASE_ITEMS);
            end
        end

        // drain and let the pipeline settle
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("%0d commands, %0d results: %0d copies, %0d trigger hits, %0d irq events",
                 items_sent, results_seen, copies_seen, hits_seen, irqs_seen);
        $display("both mode settings; input held off %0d cycles by result backpressure",
                 blocked_cycles);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/dmac_pkg.sv
hdl/dmac_ctrl.sv
hdl/dmac_chan.sv
hdl/dmac_datapath.sv
hdl/four_channel_dma_controller_unit.sv
sim/tb_four_channel_dma_controller_unit.sv
